[rtl/tof_pkg.sv]
// Shared types and constants for the telnet option filter.
// Used by every module of the block; depends on nothing.
`default_nettype none

package tof_pkg;

    // Telnet command and option bytes
    localparam logic [7:0] B_IAC    = 8'd255;
    localparam logic [7:0] B_DONT   = 8'd254;
    localparam logic [7:0] B_DO     = 8'd253;
    localparam logic [7:0] B_WONT   = 8'd252;
    localparam logic [7:0] B_WILL   = 8'd251;
    localparam logic [7:0] B_GA     = 8'd249;
    localparam logic [7:0] B_IP     = 8'd244;
    localparam logic [7:0] B_EOR    = 8'd239;
    localparam logic [7:0] OPT_ECHO = 8'd1;
    localparam logic [7:0] OPT_SGA  = 8'd3;
    localparam logic [7:0] OPT_EOR  = 8'd25;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] PROMPT_MARK = 8'd255;

    // Result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_REPLY = 2'd1;
    localparam logic [1:0] KIND_DISC  = 2'd2;

    // Command queue between front and back
    localparam int CMD_DEPTH = 4;
    localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
    localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

    // Reply beats: IAC, verb, option
    localparam logic [1:0] BEAT_IAC  = 2'd0;
    localparam logic [1:0] BEAT_VERB = 2'd1;
    localparam logic [1:0] BEAT_OPT  = 2'd2;

    typedef enum logic [2:0] {
        PH_DATA = 3'd0,
        PH_CMD  = 3'd1,
        PH_WILL = 3'd2,
        PH_WONT = 3'd3,
        PH_DO   = 3'd4,
        PH_DONT = 3'd5
    } phase_t;

    typedef enum logic [1:0] {
        CMD_DATA  = 2'd0,
        CMD_DISC  = 2'd1,
        CMD_REPLY = 2'd2
    } cmd_op_t;

    // One classified action. data: arg is the byte. reply: IAC verb arg.
    typedef struct packed {
        cmd_op_t    op;
        logic [7:0] verb;
        logic [7:0] arg;
    } cmd_t;

endpackage

`default_nettype wire

[rtl/telnet_option_filter_core.sv]
// Top level of the telnet receive filter: front end, command queue, back end.
// Depends on tof_pkg, tof_front, tof_cmd_fifo and tof_back.
`default_nettype none

// Streaming telnet receive filter. Received bytes enter through a queue-style
// port (push/full) at up to one byte per clock; results leave through a
// queue-style port (empty/pop) at up to one result per clock. Plain data
// passes through, IAC sequences are stripped, IAC GA / IAC EOR become data
// byte 255, CR LF / LF CR pairs and lone CR or LF become one newline (10).
// WILL/WONT/DO/DONT for EOR, WILL/DO for SGA, ECHO requests as the echo
// flag calls for them and DO for unknown options give a three-byte reply as
// three reply transfers, out_last set on the third. IAC IP gives one
// disconnect transfer and the block then swallows every byte until reset.
// Each input byte is classified in the cycle it is accepted and stored as
// at most one command in a 4-deep queue; the back end turns a command into
// its results. The first result of a byte passes the command queue and then
// the output register before it shows on the result ports. full rises only
// when replies arrive faster than the result side can drain them (or when
// pop is held low).

module telnet_option_filter_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] in_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [1:0]      out_kind,
    output logic [7:0]      out_value,
    output logic            out_last
);
    import tof_pkg::*;

    cmd_t front_cmd;
    logic front_cmd_valid;
    logic accept;
    cmd_t q_cmd;
    logic q_empty;
    logic q_pop;

    // every accepted byte updates parse state, whether or not it yields output
    assign accept = push && !full;

    tof_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .in_byte   (in_byte),
        .cmd       (front_cmd),
        .cmd_valid (front_cmd_valid)
    );

    tof_cmd_fifo u_cmd_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept && front_cmd_valid),
        .wr_data (front_cmd),
        .rd_en   (q_pop),
        .rd_data (q_cmd),
        .full    (full),
        .empty   (q_empty)
    );

    tof_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (q_cmd),
        .cmd_avail (!q_empty),
        .cmd_pop   (q_pop),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_last  (out_last),
        .empty     (empty),
        .pop       (pop)
    );

endmodule

`default_nettype wire

[rtl/tof_front.sv]
// Front end: parse state machine, echo / line-end / halt flags, and
// classification of each byte into at most one command. Uses tof_pkg.
`default_nettype none

module tof_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [7:0]    in_byte,
    output tof_pkg::cmd_t      cmd,
    output logic               cmd_valid
);
    import tof_pkg::*;

    phase_t phase_reg, phase_next;
    logic   echo_reg, echo_next;
    logic   drop_lf_reg, drop_lf_next;
    logic   drop_cr_reg, drop_cr_next;
    logic   halted_reg, halted_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_DATA;
            echo_reg    <= 1'b1;
            drop_lf_reg <= 1'b0;
            drop_cr_reg <= 1'b0;
            halted_reg  <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            echo_reg    <= echo_next;
            drop_lf_reg <= drop_lf_next;
            drop_cr_reg <= drop_cr_next;
            halted_reg  <= halted_next;
        end
    end

    // Next state
    always_comb
    begin
        phase_next   = phase_reg;
        echo_next    = echo_reg;
        drop_lf_next = 1'b0;
        drop_cr_next = 1'b0;
        halted_next  = halted_reg;
        if (halted_reg)
        begin
            drop_lf_next = drop_lf_reg;
            drop_cr_next = drop_cr_reg;
        end
        else
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (in_byte == CH_CR)
                    begin
                        drop_lf_next = !drop_cr_reg;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        drop_cr_next = !drop_lf_reg;
                    end
                    else if (in_byte == B_IAC)
                    begin
                        phase_next = PH_CMD;
                    end
                end
                PH_CMD:
                begin
                    case (in_byte)
                        B_IP:    begin phase_next = PH_DATA; halted_next = 1'b1; end
                        B_WILL:  phase_next = PH_WILL;
                        B_WONT:  phase_next = PH_WONT;
                        B_DO:    phase_next = PH_DO;
                        B_DONT:  phase_next = PH_DONT;
                        default: phase_next = PH_DATA;
                    endcase
                end
                PH_WILL:
                begin
                    phase_next = PH_DATA;
                    if (in_byte == OPT_ECHO)
                    begin
                        echo_next = 1'b0;
                    end
                end
                PH_WONT:
                begin
                    phase_next = PH_DATA;
                    if (in_byte == OPT_ECHO)
                    begin
                        echo_next = 1'b1;
                    end
                end
                PH_DONT:
                begin
                    phase_next = PH_DATA;
                    if (in_byte == OPT_ECHO)
                    begin
                        echo_next = 1'b0;
                    end
                end
                default: phase_next = PH_DATA;
            endcase
        end
    end

    // Command output
    always_comb
    begin
        cmd_valid = 1'b0;
        cmd.op    = CMD_DATA;
        cmd.verb  = B_IAC;
        cmd.arg   = in_byte;
        if (!halted_reg)
        begin
            case (phase_reg)
                PH_DATA:
                begin
                    if (in_byte == CH_CR)
                    begin
                        cmd_valid = !drop_cr_reg;
                        cmd.arg   = CH_LF;
                    end
                    else if (in_byte == CH_LF)
                    begin
                        cmd_valid = !drop_lf_reg;
                        cmd.arg   = CH_LF;
                    end
                    else
                    begin
                        cmd_valid = (in_byte != B_IAC);
                    end
                end
                PH_CMD:
                begin
                    if (in_byte == B_IP)
                    begin
                        cmd_valid = 1'b1;
                        cmd.op    = CMD_DISC;
                    end
                    else if (in_byte == B_GA || in_byte == B_EOR)
                    begin
                        cmd_valid = 1'b1;
                        cmd.arg   = PROMPT_MARK;
                    end
                end
                PH_WILL:
                begin
                    cmd.op = CMD_REPLY;
                    if (in_byte == OPT_ECHO)
                    begin
                        cmd_valid = echo_reg;
                        cmd.verb  = B_DO;
                    end
                    else if (in_byte == OPT_SGA)
                    begin
                        cmd_valid = 1'b1;
                        cmd.verb  = B_DONT;
                    end
                    else if (in_byte == OPT_EOR)
                    begin
                        cmd_valid = 1'b1;
                        cmd.verb  = B_DO;
                    end
                end
                PH_WONT:
                begin
                    cmd.op   = CMD_REPLY;
                    cmd.verb = B_DONT;
                    if (in_byte == OPT_ECHO)
                    begin
                        cmd_valid = !echo_reg;
                    end
                    else if (in_byte == OPT_EOR)
                    begin
                        cmd_valid = 1'b1;
                    end
                end
                PH_DO:
                begin
                    // unknown options are refused with WONT
                    cmd.op    = CMD_REPLY;
                    cmd_valid = 1'b1;
                    cmd.verb  = B_WONT;
                    if (in_byte == OPT_ECHO)
                    begin
                        cmd_valid = !echo_reg;
                        cmd.verb  = B_WILL;
                    end
                    else if (in_byte == OPT_EOR)
                    begin
                        cmd.verb = B_WILL;
                    end
                end
                PH_DONT:
                begin
                    cmd.op   = CMD_REPLY;
                    cmd.verb = B_WONT;
                    if (in_byte == OPT_ECHO)
                    begin
                        cmd_valid = echo_reg;
                    end
                    else if (in_byte == OPT_EOR)
                    begin
                        cmd_valid = 1'b1;
                    end
                end
                default: cmd_valid = 1'b0;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/tof_cmd_fifo.sv]
// Short command queue between front and back ends.
// Flop-based ring with a fill count. Uses tof_pkg.
`default_nettype none

module tof_cmd_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          wr_en,
    input  wire tof_pkg::cmd_t wr_data,
    input  wire logic          rd_en,
    output tof_pkg::cmd_t      rd_data,
    output logic               full,
    output logic               empty
);
    import tof_pkg::*;

    cmd_t                 mem_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;
    logic                 do_wr, do_rd;

    assign full    = (count_reg == CMD_CNT_W'(CMD_DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

`default_nettype wire

[rtl/tof_back.sv]
// Back end: expands queued commands into result transfers and holds
// the output register. Uses tof_pkg.
`default_nettype none

module tof_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tof_pkg::cmd_t cmd,
    input  wire logic          cmd_avail,
    output logic               cmd_pop,
    output logic [1:0]         out_kind,
    output logic [7:0]         out_value,
    output logic               out_last,
    output logic               empty,
    input  wire logic          pop
);
    import tof_pkg::*;

    logic       valid_reg, valid_next;
    logic [1:0] beat_reg, beat_next;
    logic [1:0] kind_reg, kind_next;
    logic [7:0] value_reg, value_next;
    logic       last_reg, last_next;
    logic       load;

    assign empty     = !valid_reg;
    assign out_kind  = kind_reg;
    assign out_value = value_reg;
    assign out_last  = last_reg;

    // output register free now or freed by this transfer
    assign load    = cmd_avail && (!valid_reg || pop);
    assign cmd_pop = load && last_next;

    always_comb
    begin
        kind_next  = KIND_DATA;
        value_next = cmd.arg;
        last_next  = 1'b1;
        case (cmd.op)
            CMD_DATA: ;
            CMD_DISC:
            begin
                kind_next  = KIND_DISC;
                value_next = 8'd0;
            end
            CMD_REPLY:
            begin
                kind_next = KIND_REPLY;
                case (beat_reg)
                    BEAT_IAC:  begin value_next = B_IAC;    last_next = 1'b0; end
                    BEAT_VERB: begin value_next = cmd.verb; last_next = 1'b0; end
                    default:   value_next = cmd.arg;
                endcase
            end
            default: kind_next = KIND_DATA;
        endcase

        valid_next = valid_reg;
        beat_next  = beat_reg;
        if (load)
        begin
            valid_next = 1'b1;
            beat_next  = last_next ? BEAT_IAC : beat_reg + 1'b1;
        end
        else if (pop)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            beat_reg  <= BEAT_IAC;
        end
        else
        begin
            valid_reg <= valid_next;
            beat_reg  <= beat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            kind_reg  <= kind_next;
            value_reg <= value_next;
            last_reg  <= last_next;
        end
    end

endmodule

`default_nettype wire

[rtl/tof_checker.sv]
// Port-level checks for telnet_option_filter_core, attached by bind.
// Uses tof_pkg for result kinds.
`default_nettype none

module tof_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       push,
    input wire logic       full,
    input wire logic [7:0] in_byte,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] out_kind,
    input wire logic [7:0] out_value,
    input wire logic       out_last
);
    import tof_pkg::*;

    // a waiting result holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(out_kind) && $stable(out_value)
                              && $stable(out_last)))
        else $error("result changed while waiting");

    a_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (out_kind == KIND_DATA || out_kind == KIND_REPLY
                    || out_kind == KIND_DISC))
        else $error("bad result kind");

    a_single: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind != KIND_REPLY) |-> out_last)
        else $error("data or disconnect without last");

    a_disc: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && out_kind == KIND_DISC) |-> (out_value == 8'd0))
        else $error("disconnect with nonzero value");

    // nothing follows a disconnect
    a_halt: assert property (@(posedge clk) disable iff (!rst_n)
        (pop && !empty && out_kind == KIND_DISC) |=> empty)
        else $error("result after disconnect");

endmodule

bind telnet_option_filter_core tof_checker u_tof_checker (.*);

`default_nettype wire

[dv/telnet_option_filter_core_test.sv]
// Self-checking testbench for telnet_option_filter_core: directed tables around random
// telnet streams; results checked in order against typed rows or an in-bench model.
// Depends on tof_pkg and the RTL of telnet_option_filter_core; nothing else.
`default_nettype none

module telnet_option_filter_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tof_pkg::*;

    // Row kinds of the directed table: expectation from the model, none, or one typed result
    localparam int ROW_PREDICT = -1;
    localparam int ROW_NONE    = 0;
    localparam int ROW_ONE     = 1;

    localparam int DIRECTED_ROWS   = 27;
    localparam int HALT_ROWS       = 6;
    localparam int RANDOM_ITEMS    = 400;
    localparam int HOLD_OFF_AT     = 150;   // random byte count at which pop goes quiet
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int DRAIN_CYCLES    = 16;    // first result passes the command queue and the output register
    // Longest legal quiet stretch is the pop hold-off or a long pop stall or sender gap;
    // several times that still ends a hung run quickly.
    localparam int WATCHDOG_LIMIT  = 4000;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] value;
        logic       last;
    } result_t;

    typedef struct packed {
        logic [7:0] b;
        int         given;
        logic [1:0] kind;
        logic [7:0] value;
    } stim_row_t;

    logic       clk;
    logic       rst_n;
    logic       push;
    logic       full;
    logic [7:0] in_byte;
    logic       empty;
    logic       pop;
    logic [1:0] out_kind;
    logic [7:0] out_value;
    logic       out_last;

    telnet_option_filter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .in_byte   (in_byte),
        .empty     (empty),
        .pop       (pop),
        .out_kind  (out_kind),
        .out_value (out_value),
        .out_last  (out_last)
    );

    // ------------------------------------------------------------------
    // Filter model state, mirrors the block's own state after reset
    // ------------------------------------------------------------------
    phase_t rx_phase   = PH_DATA;
    logic   echo_local = 1'b1;
    logic   skip_lf    = 1'b0;   // a CR just made a newline
    logic   skip_cr    = 1'b0;   // an LF just made a newline
    logic   rx_halted  = 1'b0;

    result_t step_results[$];     // results of the byte just filtered
    result_t pending_results[$];  // results owed by the block, oldest first

    int  fails        = 0;
    int  quiet_cycles = 0;
    int  items_sent   = 0;
    bit  hold_off_req = 1'b0;
    bit  no_idle      = 1'b0;

    stim_row_t opening_rows[DIRECTED_ROWS];
    stim_row_t halt_rows[HALT_ROWS];

    function automatic void emit(input logic [1:0] kind, input logic [7:0] value,
                                 input logic last);
        result_t r;
        r.kind  = kind;
        r.value = value;
        r.last  = last;
        step_results.push_back(r);
    endfunction

    // Replies always go out as IAC, verb, option; last marks the option beat
    function automatic void emit_reply(input logic [7:0] verb, input logic [7:0] opt);
        emit(KIND_REPLY, B_IAC, 1'b0);
        emit(KIND_REPLY, verb, 1'b0);
        emit(KIND_REPLY, opt, 1'b1);
    endfunction

    // Answer to the option byte of WILL/WONT/DO/DONT; ECHO answers depend on the echo flag
    function automatic void answer_option(input phase_t ph, input logic [7:0] opt);
        case (ph)
            PH_WILL:
            begin
                if (opt == OPT_ECHO)
                begin
                    if (echo_local)
                    begin
                        echo_local = 1'b0;
                        emit_reply(B_DO, OPT_ECHO);
                    end
                end
                else if (opt == OPT_SGA)
                    emit_reply(B_DONT, OPT_SGA);
                else if (opt == OPT_EOR)
                    emit_reply(B_DO, OPT_EOR);
            end
            PH_WONT:
            begin
                if (opt == OPT_ECHO)
                begin
                    if (!echo_local)
                    begin
                        echo_local = 1'b1;
                        emit_reply(B_DONT, OPT_ECHO);
                    end
                end
                else if (opt == OPT_EOR)
                    emit_reply(B_DONT, OPT_EOR);
            end
            PH_DO:
            begin
                if (opt == OPT_ECHO)
                begin
                    if (!echo_local)
                        emit_reply(B_WILL, OPT_ECHO);
                end
                else if (opt == OPT_SGA)
                    emit_reply(B_WONT, OPT_SGA);
                else if (opt == OPT_EOR)
                    emit_reply(B_WILL, OPT_EOR);
                else
                    emit_reply(B_WONT, opt);   // unknown DO is refused
            end
            default:   // after DONT
            begin
                if (opt == OPT_ECHO)
                begin
                    if (echo_local)
                    begin
                        echo_local = 1'b0;
                        emit_reply(B_WONT, OPT_ECHO);
                    end
                end
                else if (opt == OPT_EOR)
                    emit_reply(B_WONT, OPT_EOR);
            end
        endcase
    endfunction

    // One received byte through the filter model; results land in step_results
    function automatic void filter_byte(input logic [7:0] b);
        phase_t ph;
        if (rx_halted)
            return;
        if (rx_phase == PH_DATA)
        begin
            if (b == CH_CR)
            begin
                skip_lf = 1'b0;
                if (skip_cr)
                    skip_cr = 1'b0;          // completes LF CR
                else
                begin
                    skip_lf = 1'b1;
                    emit(KIND_DATA, CH_LF, 1'b1);
                end
            end
            else if (b == CH_LF)
            begin
                skip_cr = 1'b0;
                if (skip_lf)
                    skip_lf = 1'b0;          // completes CR LF
                else
                begin
                    skip_cr = 1'b1;
                    emit(KIND_DATA, CH_LF, 1'b1);
                end
            end
            else
            begin
                skip_lf = 1'b0;
                skip_cr = 1'b0;
                if (b == B_IAC)
                    rx_phase = PH_CMD;
                else
                    emit(KIND_DATA, b, 1'b1);
            end
        end
        else
        begin
            // any byte of an IAC sequence breaks a pending line-end pair
            skip_lf  = 1'b0;
            skip_cr  = 1'b0;
            ph       = rx_phase;
            rx_phase = PH_DATA;
            if (ph == PH_CMD)
            begin
                case (b)
                    B_IP:
                    begin
                        rx_halted = 1'b1;
                        emit(KIND_DISC, 8'd0, 1'b1);
                    end
                    B_GA, B_EOR: emit(KIND_DATA, PROMPT_MARK, 1'b1);
                    B_WILL:      rx_phase = PH_WILL;
                    B_WONT:      rx_phase = PH_WONT;
                    B_DO:        rx_phase = PH_DO;
                    B_DONT:      rx_phase = PH_DONT;
                    default:     ;   // second IAC, SB and the rest are swallowed
                endcase
            end
            else
                answer_option(ph, b);
        end
    endfunction

    // ------------------------------------------------------------------
    // Clock and the cycle watchdog
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // A cycle is quiet when neither side completes a transfer
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("telnet_option_filter_core: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side: drive pop, check every transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: kind %0d value %0d last %0d",
                       out_kind, out_value, out_last);
                fails++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_kind !== want.kind)
                begin
                    $error("out_kind: expected %0d, got %0d", want.kind, out_kind);
                    fails++;
                end
                if (out_value !== want.value)
                begin
                    $error("out_value: expected %0d, got %0d", want.value, out_value);
                    fails++;
                end
                if (out_last !== want.last)
                begin
                    $error("out_last: expected %0d, got %0d", want.last, out_last);
                    fails++;
                end
            end
        end
    end

    // pop runs in bursts with mostly short stalls, now and then a long one,
    // and once a long hold-off so that the internal queue fills and full rises
    initial
    begin
        int run;
        int stall;
        int sel;
        pop <= 1'b0;
        wait (rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            else
            begin
                run = $urandom_range(1, 24);
                pop <= 1'b1;
                repeat (run) @(posedge clk);
                sel = $urandom_range(0, 99);
                if (sel < 40)
                    stall = 0;
                else if (sel < 90)
                    stall = $urandom_range(1, 3);
                else
                    stall = $urandom_range(10, 50);
                if (stall > 0)
                begin
                    pop <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte until it is taken, then run it through the model.
    // Typed rows queue their written-down result; the model still steps to keep state.
    task automatic send_byte(input logic [7:0] b, input int given,
                             input logic [1:0] kind, input logic [7:0] value);
        result_t r;
        push    <= 1'b1;
        in_byte <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        step_results.delete();
        filter_byte(b);
        if (given == ROW_PREDICT)
        begin
            foreach (step_results[i])
                pending_results.push_back(step_results[i]);
        end
        else if (given == ROW_ONE)
        begin
            r.kind  = kind;
            r.value = value;
            r.last  = 1'b1;
            pending_results.push_back(r);
        end
        items_sent++;
    endtask

    // Idle between transfers: often none, mostly short, a few long,
    // with stretches of back-to-back bytes
    task automatic sender_gap();
        int gap;
        int sel;
        if ($urandom_range(0, 39) == 0)
            no_idle = !no_idle;
        sel = $urandom_range(0, 99);
        if (no_idle || sel < 50)
            gap = 0;
        else if (sel < 92)
            gap = $urandom_range(1, 3);
        else
            gap = $urandom_range(10, 40);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Random byte; IP right after IAC would halt the block, so it becomes GA
    // until the closing table
    task automatic send_random(input logic [7:0] b);
        logic [7:0] v;
        v = b;
        if (rx_phase == PH_CMD && v == B_IP)
            v = B_GA;
        send_byte(v, ROW_PREDICT, KIND_DATA, 8'd0);
        sender_gap();
    endtask

    function automatic logic [7:0] pick_verb();
        case ($urandom_range(0, 3))
            0:       return B_WILL;
            1:       return B_WONT;
            2:       return B_DO;
            default: return B_DONT;
        endcase
    endfunction

    function automatic logic [7:0] pick_option();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return OPT_ECHO;
        if (sel < 5)
            return OPT_SGA;
        if (sel < 7)
            return OPT_EOR;
        return 8'($urandom_range(0, 255));
    endfunction

    // Mostly well-formed telnet traffic with random content, plus noise and
    // cut-off IAC sequences
    task automatic send_random_sequence();
        int sel;
        int n;
        sel = $urandom_range(0, 99);
        if (sel < 35)
        begin
            send_random(B_IAC);
            send_random(pick_verb());
            send_random(pick_option());
        end
        else if (sel < 45)
        begin
            send_random(B_IAC);
            send_random($urandom_range(0, 1) ? B_GA : B_EOR);
        end
        else if (sel < 50)
        begin
            send_random(B_IAC);
            send_random(8'($urandom_range(0, 255)));
        end
        else if (sel < 65)
        begin
            n = $urandom_range(1, 3);
            repeat (n)
                send_random($urandom_range(0, 1) ? CH_CR : CH_LF);
        end
        else if (sel < 90)
            send_random(8'($urandom_range(0, 255)));
        else
        begin
            // IAC, maybe a verb, then the sequence is cut by whatever comes next
            send_random(B_IAC);
            if ($urandom_range(0, 1))
                send_random(pick_verb());
        end
    endtask

    initial
    begin
        push    <= 1'b0;
        in_byte <= 8'd0;
        rst_n   <= 1'b0;

        // Opening table: data extremes, line-end pairing, prompt markers,
        // each verb once against ECHO while the echo flag goes through both states,
        // refused unknown DO, and a doubled IAC that is swallowed
        opening_rows = '{
            '{8'h00,    ROW_ONE,     KIND_DATA, 8'h00},
            '{8'hFE,    ROW_ONE,     KIND_DATA, 8'hFE},
            '{CH_CR,    ROW_ONE,     KIND_DATA, CH_LF},
            '{CH_LF,    ROW_NONE,    KIND_DATA, 8'h00},
            '{CH_LF,    ROW_ONE,     KIND_DATA, CH_LF},
            '{CH_CR,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_GA,     ROW_ONE,     KIND_DATA, PROMPT_MARK},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_EOR,    ROW_ONE,     KIND_DATA, PROMPT_MARK},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_WILL,   ROW_NONE,    KIND_DATA, 8'h00},
            '{OPT_ECHO, ROW_PREDICT, KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_DO,     ROW_NONE,    KIND_DATA, 8'h00},
            '{OPT_ECHO, ROW_PREDICT, KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_WONT,   ROW_NONE,    KIND_DATA, 8'h00},
            '{OPT_ECHO, ROW_PREDICT, KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_DONT,   ROW_NONE,    KIND_DATA, 8'h00},
            '{OPT_ECHO, ROW_PREDICT, KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_DO,     ROW_NONE,    KIND_DATA, 8'h00},
            '{8'hC8,    ROW_PREDICT, KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00},
            '{B_IAC,    ROW_NONE,    KIND_DATA, 8'h00}
        };

        // Closing table: IAC IP asks for a disconnect, then every byte is swallowed
        halt_rows = '{
            '{B_IAC, ROW_NONE, KIND_DATA, 8'h00},
            '{B_IP,  ROW_ONE,  KIND_DISC, 8'h00},
            '{8'h41, ROW_NONE, KIND_DATA, 8'h00},
            '{B_IAC, ROW_NONE, KIND_DATA, 8'h00},
            '{CH_CR, ROW_NONE, KIND_DATA, 8'h00},
            '{8'h00, ROW_NONE, KIND_DATA, 8'h00}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (opening_rows[i])
        begin
            send_byte(opening_rows[i].b, opening_rows[i].given,
                      opening_rows[i].kind, opening_rows[i].value);
            sender_gap();
        end

        // Random traffic; partway in, the result side goes quiet for a long
        // stretch while bytes keep coming so the block has to back up
        while (items_sent < DIRECTED_ROWS + RANDOM_ITEMS)
        begin
            if (items_sent >= DIRECTED_ROWS + HOLD_OFF_AT && items_sent < DIRECTED_ROWS +
                HOLD_OFF_AT + 4 && !hold_off_req)
                hold_off_req = 1'b1;
            send_random_sequence();
        end

        // Close any open IAC sequence so the closing table starts in the data phase
        while (rx_phase != PH_DATA)
            send_random(8'h20);

        foreach (halt_rows[i])
        begin
            send_byte(halt_rows[i].b, halt_rows[i].given,
                      halt_rows[i].kind, halt_rows[i].value);
            sender_gap();
        end
        push <= 1'b0;

        // Drain; the watchdog catches results that never come
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fails == 0)
            $display("telnet_option_filter_core: match");
        else
            $display("telnet_option_filter_core: mismatch");
        $finish;
    end

endmodule

`default_nettype wire

[files.f]
rtl/tof_pkg.sv
rtl/tof_front.sv
rtl/tof_cmd_fifo.sv
rtl/tof_back.sv
rtl/telnet_option_filter_core.sv
rtl/tof_checker.sv
dv/telnet_option_filter_core_test.sv
